// ----- hdl/srr_pkg.sv -----
// Shared constants and types for the signed rounded reciprocal block.
package srr_pkg;

  // Default data path width
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Per-item flags carried alongside the data through the pipeline
  typedef struct packed {
    logic neg;   // input was negative, result gets negated
    logic zero;  // input was zero, result forced to all ones
  } srr_flags_t;

endpackage

// ----- hdl/srr_front.sv -----
// Input stage: registers the magnitude, half magnitude and sign/zero flags.
module srr_front #(
  parameter int unsigned DATA_WIDTH = srr_pkg::DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [DATA_WIDTH-1:0]   value_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DATA_WIDTH-1:0]   mag,
  output logic [DATA_WIDTH-1:0]   half,
  output srr_pkg::srr_flags_t     flags
);

  logic                  sgn;
  logic [DATA_WIDTH-1:0] mag_next;

  // Two's complement magnitude, modulo 2^DATA_WIDTH
  assign sgn      = value_in[DATA_WIDTH-1];
  assign mag_next = sgn ? (~value_in + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : value_in;

  assign in_ready = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Payload; half is an arithmetic shift so the most negative input never rounds
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mag        <= mag_next;
      half       <= {mag_next[DATA_WIDTH-1], mag_next[DATA_WIDTH-1:1]};
      flags.neg  <= sgn;
      flags.zero <= (value_in == '0);
    end
  end

endmodule

// ----- hdl/srr_cell.sv -----
// One restoring-division cell: produces one quotient bit of all-ones / mag.
module srr_cell #(
  parameter int unsigned DATA_WIDTH = srr_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] mag_in,
  input  logic [DATA_WIDTH-1:0] half_in,
  input  logic [DATA_WIDTH-1:0] rem_in,
  input  logic [DATA_WIDTH-1:0] quo_in,
  input  srr_pkg::srr_flags_t   flags_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] mag,
  output logic [DATA_WIDTH-1:0] half,
  output logic [DATA_WIDTH-1:0] rem,
  output logic [DATA_WIDTH-1:0] quo,
  output srr_pkg::srr_flags_t   flags
);

  logic [DATA_WIDTH:0]   trial;
  logic                  fits;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] rem_next;

  // Bring down the next dividend bit (always one) and try the subtraction
  assign trial    = {rem_in, 1'b1};
  assign diff     = trial - {1'b0, mag_in};
  assign fits     = !diff[DATA_WIDTH];
  assign rem_next = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];

  assign in_ready = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Payload hand-on to the next cell
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mag   <= mag_in;
      half  <= half_in;
      rem   <= rem_next;
      quo   <= {quo_in[DATA_WIDTH-2:0], fits};
      flags <= flags_in;
    end
  end

endmodule

// ----- hdl/srr_back.sv -----
// Output stage: round-up, sign re-application and the result register.
module srr_back #(
  parameter int unsigned DATA_WIDTH = srr_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] half_in,
  input  logic [DATA_WIDTH-1:0] rem_in,
  input  logic [DATA_WIDTH-1:0] quo_in,
  input  srr_pkg::srr_flags_t   flags_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] reciprocal_bits,
  output logic                  zero_divisor
);

  logic                  round_up;
  logic [DATA_WIDTH-1:0] base;
  logic [DATA_WIDTH-1:0] res;

  // q, q+1, -q = ~q+1 and -(q+1) = ~q all from one adder
  assign round_up = (half_in < rem_in);
  assign base     = flags_in.neg ? ~quo_in : quo_in;
  assign res      = base + {{(DATA_WIDTH-1){1'b0}}, (round_up != flags_in.neg)};

  assign in_ready = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Result register; zero input forces all ones
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      reciprocal_bits <= flags_in.zero ? '1 : res;
      zero_divisor    <= flags_in.zero;
    end
  end

endmodule

// ----- hdl/signed_rounded_reciprocal_top.sv -----
// Top level of the signed rounded reciprocal: input stage, divider cells, output stage.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   input    | in_valid / in_ready  | value_in [DATA_WIDTH-1:0] signed
//   output   | out_valid / out_ready| reciprocal_bits [DATA_WIDTH-1:0], zero_divisor
//
// One item per cycle sustained while out_ready is high. Stages in order: input
// stage, one cell per quotient bit, output stage. Each stage has its own valid
// and ready, so bubbles close up while the output is stalled and the chain keeps
// taking items until it is full. Synchronous reset clears only the valid flags.
module signed_rounded_reciprocal_top #(
  parameter int unsigned DATA_WIDTH = srr_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] value_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] reciprocal_bits,
  output logic                  zero_divisor
);

  // Chain links: index 0 is the input stage, index k+1 the output of cell k
  logic                  c_valid [0:DATA_WIDTH];
  logic                  c_ready [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] c_mag   [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] c_half  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] c_rem   [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] c_quo   [0:DATA_WIDTH];
  srr_pkg::srr_flags_t   c_flags [0:DATA_WIDTH];

  // Input stage
  srr_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value_in  (value_in),
    .out_valid (c_valid[0]),
    .out_ready (c_ready[0]),
    .mag       (c_mag[0]),
    .half      (c_half[0]),
    .flags     (c_flags[0])
  );

  // Partial remainder and quotient start cleared
  assign c_rem[0] = '0;
  assign c_quo[0] = '0;

  // One cell per quotient bit
  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
    srr_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[k]),
      .in_ready  (c_ready[k]),
      .mag_in    (c_mag[k]),
      .half_in   (c_half[k]),
      .rem_in    (c_rem[k]),
      .quo_in    (c_quo[k]),
      .flags_in  (c_flags[k]),
      .out_valid (c_valid[k+1]),
      .out_ready (c_ready[k+1]),
      .mag       (c_mag[k+1]),
      .half      (c_half[k+1]),
      .rem       (c_rem[k+1]),
      .quo       (c_quo[k+1]),
      .flags     (c_flags[k+1])
    );
  end

  // Output stage
  srr_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (c_valid[DATA_WIDTH]),
    .in_ready        (c_ready[DATA_WIDTH]),
    .half_in         (c_half[DATA_WIDTH]),
    .rem_in          (c_rem[DATA_WIDTH]),
    .quo_in          (c_quo[DATA_WIDTH]),
    .flags_in        (c_flags[DATA_WIDTH]),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .reciprocal_bits (reciprocal_bits),
    .zero_divisor    (zero_divisor)
  );

  // Zero flag in the input stage matches the registered magnitude
  a_front_zero: assert property (@(posedge clk) disable iff (rst)
    c_valid[0] |-> (c_flags[0].zero == (c_mag[0] == '0)))
    else $error("zero flag disagrees with magnitude");

  // A finished division leaves a remainder below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (c_valid[DATA_WIDTH] && !c_flags[DATA_WIDTH].zero) |->
      (c_rem[DATA_WIDTH] < c_mag[DATA_WIDTH]))
    else $error("final remainder not below divisor");

  // Zero divisor always comes out as all ones
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_divisor) |-> (&reciprocal_bits))
    else $error("zero divisor result not all ones");

  // A zero input accepted shows up flagged in the input stage next cycle
  a_zero_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (value_in == '0)) |=> (c_valid[0] && c_flags[0].zero))
    else $error("zero input not flagged");

endmodule
